### src/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/sqs_pkg.sv
// Shared types and codes for the shift queue with search.
// No dependencies.
`timescale 1ns / 1ps

package sqs_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_ENQ    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQ    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic                       shift;
        logic                       load_match;
        logic                       shift_match;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

endpackage

### src/sqs_cell.sv
// One queue position: holds a word and a search match bit.
// Depends on sqs_pkg.
`timescale 1ns / 1ps

module sqs_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sqs_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                i_wr,
    input  logic                                i_live,
    input  logic signed [sqs_pkg::VALUE_W-1:0]  i_next_entry,
    input  logic                                i_next_match,
    output logic signed [sqs_pkg::VALUE_W-1:0]  o_entry,
    output logic                                o_match
);

    logic signed [sqs_pkg::VALUE_W-1:0] r_entry;
    logic                               r_match;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_ctrl.value;
        end else if (i_ctrl.shift) begin
            r_entry <= i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.load_match) begin
            r_match <= i_live && (r_entry == i_ctrl.value);
        end else if (i_ctrl.shift_match) begin
            r_match <= i_next_match;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

### src/shift_queue_with_search.sv
// Shift queue with search: top level, control sequencer and the row of cells.
// Depends on sqs_pkg, sqs_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Front-aligned queue of signed 32-bit words, head at position 0. An item is
// taken when start is high and busy is low. Enqueue, dequeue, peek, clear and
// unused action codes do not raise busy: the result appears on the cycle after
// the transfer and a new item may be taken in that same cycle. A search
// captures a match bit in every cell at once, then walks the match bits down
// the cell chain one position per cycle; busy stays high until the first match
// reaches position 0 or the walk has covered every occupied position, and the
// result follows on the next cycle. Each result is on the output ports for
// exactly one cycle, marked by o_done; the receiver cannot hold it off, so it
// must take every result as it comes.
module shift_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sqs_pkg::CAP_W-1:0]           i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [sqs_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [sqs_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_done,
    output logic [sqs_pkg::STATUS_W-1:0]        o_status,
    output logic signed [sqs_pkg::VALUE_W-1:0]  o_data,
    output logic                                o_found,
    output logic [sqs_pkg::INDEX_W-1:0]         o_found_index,
    output logic [sqs_pkg::COUNT_W-1:0]         o_count,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > sqs_pkg::CAP_W) ? OW : sqs_pkg::CAP_W;
    localparam int IW = (OW > sqs_pkg::INDEX_W) ? OW : sqs_pkg::INDEX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state                             r_state, n_state;
    logic [sqs_pkg::CAP_W-1:0]          r_capacity;
    logic [OW-1:0]                      r_occ, n_occ;
    logic [OW-1:0]                      r_idx, n_idx;
    logic                               r_done, n_done;
    logic [sqs_pkg::STATUS_W-1:0]       r_status, n_status;
    logic signed [sqs_pkg::VALUE_W-1:0] r_data, n_data;
    logic                               r_found, n_found;
    logic [sqs_pkg::INDEX_W-1:0]        r_found_index, n_found_index;
    logic [sqs_pkg::COUNT_W-1:0]        r_count, n_count;
    logic                               r_is_empty, n_is_empty;
    logic                               r_is_full, n_is_full;

    sqs_pkg::t_cell_ctrl                w_ctrl;
    logic                               w_enq;
    logic                               w_accept;
    logic [CW-1:0]                      w_cap_ext;
    logic [CW-1:0]                      w_cap_eff;
    logic                               w_full_now;
    logic [CW-1:0]                      w_next_occ_ext;
    logic [OW:0]                        w_idx_inc;
    logic [IW-1:0]                      w_idx_ext;
    logic signed [sqs_pkg::VALUE_W-1:0] w_entry [DEPTH];
    logic                               w_match [DEPTH];

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_cap_ext  = CW'(r_capacity);
    assign w_cap_eff  = (w_cap_ext > DEPTH_C) ? DEPTH_C : w_cap_ext;
    assign w_full_now = CW'(r_occ) >= w_cap_eff;
    assign w_idx_inc  = {1'b0, r_idx} + (OW + 1)'(1);
    assign w_idx_ext  = IW'(r_idx);

    always_comb begin
        n_state       = r_state;
        n_occ         = r_occ;
        n_idx         = r_idx;
        n_done        = 1'b0;
        n_status      = sqs_pkg::ST_OK;
        n_data        = '0;
        n_found       = 1'b0;
        n_found_index = '0;
        w_enq         = 1'b0;
        w_ctrl        = '{shift: 1'b0, load_match: 1'b0, shift_match: 1'b0,
                          value: i_value};
        if (r_state == S_SEARCH) begin
            if (w_match[0]) begin
                n_done        = 1'b1;
                n_found       = 1'b1;
                n_found_index = w_idx_ext[sqs_pkg::INDEX_W-1:0];
                n_state       = S_IDLE;
            end else if (w_idx_inc >= {1'b0, r_occ}) begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end else begin
                w_ctrl.shift_match = 1'b1;
                n_idx              = w_idx_inc[OW-1:0];
            end
        end else if (w_accept) begin
            n_done = 1'b1;
            case (i_action)
                sqs_pkg::ACT_ENQ: begin
                    if (w_full_now) begin
                        n_status = sqs_pkg::ST_FULL;
                    end else begin
                        w_enq = 1'b1;
                        n_occ = r_occ + OW'(1);
                    end
                end
                sqs_pkg::ACT_DEQ: begin
                    if (r_occ == '0) begin
                        n_status = sqs_pkg::ST_EMPTY;
                    end else begin
                        n_data       = w_entry[0];
                        n_occ        = r_occ - OW'(1);
                        w_ctrl.shift = 1'b1;
                    end
                end
                sqs_pkg::ACT_PEEK: begin
                    if (r_occ == '0) begin
                        n_status = sqs_pkg::ST_EMPTY;
                    end else begin
                        n_data = w_entry[0];
                    end
                end
                sqs_pkg::ACT_SEARCH: begin
                    n_done            = 1'b0;
                    w_ctrl.load_match = 1'b1;
                    n_idx             = '0;
                    n_state           = S_SEARCH;
                end
                sqs_pkg::ACT_CLEAR: begin
                    n_occ = '0;
                end
                default: begin
                end
            endcase
        end
        w_next_occ_ext = CW'(n_occ);
        n_count        = w_next_occ_ext[sqs_pkg::COUNT_W-1:0];
        n_is_empty     = (n_occ == '0);
        n_is_full      = w_next_occ_ext >= w_cap_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_idx      <= '0;
            r_done     <= 1'b0;
            r_capacity <= sqs_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_idx   <= n_idx;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
        r_status      <= n_status;
        r_data        <= n_data;
        r_found       <= n_found;
        r_found_index <= n_found_index;
        r_count       <= n_count;
        r_is_empty    <= n_is_empty;
        r_is_full     <= n_is_full;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [sqs_pkg::VALUE_W-1:0] w_next_entry;
        logic                               w_next_match;
        if (i == DEPTH - 1) begin : g_tail
            assign w_next_entry = '0;
            assign w_next_match = 1'b0;
        end else begin : g_body
            assign w_next_entry = w_entry[i+1];
            assign w_next_match = w_match[i+1];
        end
        sqs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_wr         (w_enq && (r_occ == OW'(i))),
            .i_live       (OW'(i) < r_occ),
            .i_next_entry (w_next_entry),
            .i_next_match (w_next_match),
            .o_entry      (w_entry[i]),
            .o_match      (w_match[i])
        );
    end

    assign busy          = (r_state == S_SEARCH);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;
    assign o_count       = r_count;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;

    `ASSERT_CLK(a_occ_bound, r_occ <= OW'(DEPTH), "occupancy above depth")
    `ASSERT_CLK(a_search_busy, (start && !busy && i_action == sqs_pkg::ACT_SEARCH) |=> busy, "search not entered")
    `ASSERT_CLK(a_no_done_busy, busy |-> !o_done, "result during search walk")
    `ASSERT_CLK(a_found_ok, (o_done && o_found) |-> (o_status == sqs_pkg::ST_OK && o_data == '0), "found with bad status or data")
    `ASSERT_CLK(a_empty_count, (o_done && o_is_empty) |-> (o_count == '0), "empty with nonzero count")

endmodule
